>>> rtl/atan_pkg.sv
// Shared constants, types and the elementary angle table for the CORDIC angle block.
// Depends on nothing; atan_prep, atan_cell, atan_post and atan2_angle_degrees import it.
package atan_pkg;

    // Default parameter values for the top level.
    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 7;
    localparam int ITERATIONS_DEF      = 16;

    // Fixed-point formats: guard bits on coordinates, fraction bits of the angle sum.
    localparam int GUARD_BITS = 16;
    localparam int ACC_FRAC   = 24;
    // Angle accumulator width: signed, covers -100 to +280 degrees with 24 fraction bits.
    localparam int ZW         = 35;
    localparam int OUT_WIDTH  = 16;
    localparam int TABLE_LEN  = 32;
    localparam int ELEM_WIDTH = 30;

    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180) <<< ACC_FRAC;
    localparam logic signed [ZW-1:0] FULL_TURN = ZW'(360) <<< ACC_FRAC;

    // atan(2^-i) in degrees times 2^24, rounded to nearest.
    localparam logic [ELEM_WIDTH-1:0] ELEM_ANGLE [0:TABLE_LEN-1] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
        30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234684,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115,
        30'd57,        30'd29,        30'd14,        30'd7,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    // Special-case marks that travel with each item down the chain.
    typedef struct packed {
        logic zero_y;
        logic x_neg;
    } atan_flags_t;

endpackage

>>> rtl/atan_coord_if.sv
// Item channel that carries one coordinate pair (y, x).
// Depends on nothing.
interface atan_coord_if #(
    parameter int CW = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] y_coord;
    logic signed [CW-1:0] x_coord;

    modport source (output valid, output y_coord, output x_coord, input ready);
    modport sink   (input valid, input y_coord, input x_coord, output ready);
endinterface

>>> rtl/atan_angle_if.sv
// Item channel that carries one angle result in degrees, unsigned fixed point.
// Depends on nothing.
interface atan_angle_if;
    logic        valid;
    logic        ready;
    logic [15:0] angle_deg_q7;

    modport source (output valid, output angle_deg_q7, input ready);
    modport sink   (input valid, input angle_deg_q7, output ready);
endinterface

>>> rtl/atan_prep.sv
// First cell: sign extension, reduction to the right half plane and guard bits.
// Depends on atan_pkg.
module atan_prep
    import atan_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int W  = COORD_WIDTH_DEF + GUARD_BITS + 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] x_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [W-1:0]  x_out,
    output logic signed [W-1:0]  y_out,
    output logic signed [ZW-1:0] z_out,
    output atan_flags_t          flags_out
);
    logic                 valid_reg;
    logic signed [W-1:0]  x_reg, x_next;
    logic signed [W-1:0]  y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    atan_flags_t          flags_reg, flags_next;
    logic signed [W-1:0]  x_ext, y_ext;

    assign in_ready = !valid_reg || out_ready;

    // Negate a left-half-plane vector and start its angle at 180 degrees.
    always_comb
    begin
        x_ext             = {{(W-CW){x_in[CW-1]}}, x_in};
        y_ext             = {{(W-CW){y_in[CW-1]}}, y_in};
        flags_next.zero_y = (y_in == '0);
        flags_next.x_neg  = x_in[CW-1];
        if (x_in[CW-1])
        begin
            x_next = (-x_ext) <<< GUARD_BITS;
            y_next = (-y_ext) <<< GUARD_BITS;
            z_next = HALF_TURN;
        end
        else
        begin
            x_next = x_ext <<< GUARD_BITS;
            y_next = y_ext <<< GUARD_BITS;
            z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign flags_out = flags_reg;
endmodule

>>> rtl/atan_cell.sv
// One vectoring-mode micro-rotation by atan(2^-SHIFT), registered, with its own item slot.
// Depends on atan_pkg.
module atan_cell
    import atan_pkg::*;
#(
    parameter int W     = COORD_WIDTH_DEF + GUARD_BITS + 3,
    parameter int SHIFT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    input  logic signed [ZW-1:0] z_in,
    input  atan_flags_t          flags_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [W-1:0]  x_out,
    output logic signed [W-1:0]  y_out,
    output logic signed [ZW-1:0] z_out,
    output atan_flags_t          flags_out
);
    localparam logic signed [ZW-1:0] STEP_ANGLE = ZW'(ELEM_ANGLE[SHIFT]);

    logic                 valid_reg;
    logic signed [W-1:0]  x_reg, x_next;
    logic signed [W-1:0]  y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    atan_flags_t          flags_reg;
    logic signed [W-1:0]  dx, dy;

    assign in_ready = !valid_reg || out_ready;

    // Rotate toward y = 0; arithmetic shifts round toward minus infinity.
    always_comb
    begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        if (!y_in[W-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + STEP_ANGLE;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - STEP_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            flags_reg <= flags_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign flags_out = flags_reg;
endmodule

>>> rtl/atan_post.sv
// Last two cells: move the angle into [0, 360), then round, wrap and apply special cases.
// Depends on atan_pkg.
module atan_post
    import atan_pkg::*;
#(
    parameter int AFB = ANGLE_FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [ZW-1:0] z_in,
    input  atan_flags_t          flags_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_WIDTH-1:0] angle_out
);
    localparam int            DROP      = ACC_FRAC - AFB;
    localparam logic [ZW-1:0] ROUND_BIT = ZW'(1) << (DROP - 1);
    localparam logic [ZW-1:0] WRAP      = ZW'(360) << AFB;
    localparam logic [ZW-1:0] ANGLE_180 = ZW'(180) << AFB;

    logic                 a_valid_reg;
    logic                 a_ready;
    logic [ZW-2:0]        za_reg, za_next;
    atan_flags_t          fa_reg;
    logic signed [ZW-1:0] z_fold;

    logic                 b_valid_reg;
    logic [ZW-1:0]        r_reg, r_next;
    logic [ZW-1:0]        r_sum, r_shift;

    assign a_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || a_ready;

    // Stage A: add a full turn to a negative angle, clamp what is still negative.
    always_comb
    begin
        z_fold = z_in[ZW-1] ? (z_in + FULL_TURN) : z_in;
        if (z_fold[ZW-1])
        begin
            za_next = '0;
        end
        else
        begin
            za_next = z_fold[ZW-2:0];
        end
    end

    // Stage B: round half up, wrap 360 to 0, override the y = 0 cases.
    always_comb
    begin
        r_sum   = {1'b0, za_reg} + ROUND_BIT;
        r_shift = r_sum >> DROP;
        if (fa_reg.zero_y)
        begin
            r_next = fa_reg.x_neg ? ANGLE_180 : '0;
        end
        else if (r_shift >= WRAP)
        begin
            r_next = r_shift - WRAP;
        end
        else
        begin
            r_next = r_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (a_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            za_reg <= za_next;
            fa_reg <= flags_in;
        end
        if (a_valid_reg && a_ready)
        begin
            r_reg <= r_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign angle_out = r_reg[OUT_WIDTH-1:0];

    // A folded angle stays below one full turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> ({1'b0, za_reg} < FULL_TURN))
    else $error("folded angle reached a full turn");

    // The rounded and wrapped angle stays below 360 degrees.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (r_reg < WRAP))
    else $error("rounded angle not wrapped below 360 degrees");

    // A held result is not overwritten while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !out_ready) |=> (b_valid_reg && $stable(r_reg)))
    else $error("stalled result lost or changed");
endmodule

>>> rtl/atan2_angle_degrees.sv
// Four-quadrant angle of (y, x) in degrees, pipelined vectoring-mode CORDIC.
// Items pass the prep cell, the rotation cells and post stages A and B, each registered.
// Throughput: one item per cycle unless stalled; each cell is an item slot with its own
// valid bit, and ready ripples back through the chain so a stall fills bubbles first.
// Reset clears all valid bits; the datapath registers are not reset.
// Depends on atan_pkg, atan_coord_if, atan_angle_if, atan_prep, atan_cell, atan_post.
module atan2_angle_degrees
    import atan_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int ITERATIONS      = ITERATIONS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    atan_coord_if.sink   coord,
    atan_angle_if.source angle
);
    localparam int W = COORD_WIDTH + GUARD_BITS + 3;

    // Chain links: index 0 is the output of the first cell, ITERATIONS the last rotation.
    logic                 lnk_valid [0:ITERATIONS];
    logic                 lnk_ready [0:ITERATIONS];
    logic signed [W-1:0]  lnk_x     [0:ITERATIONS];
    logic signed [W-1:0]  lnk_y     [0:ITERATIONS];
    logic signed [ZW-1:0] lnk_z     [0:ITERATIONS];
    atan_flags_t          lnk_flags [0:ITERATIONS];

    // Half-plane reduction.
    atan_prep #(
        .CW (COORD_WIDTH),
        .W  (W)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (coord.valid),
        .in_ready  (coord.ready),
        .y_in      (coord.y_coord),
        .x_in      (coord.x_coord),
        .out_valid (lnk_valid[0]),
        .out_ready (lnk_ready[0]),
        .x_out     (lnk_x[0]),
        .y_out     (lnk_y[0]),
        .z_out     (lnk_z[0]),
        .flags_out (lnk_flags[0])
    );

    // Row of micro-rotation cells.
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cell
        atan_cell #(
            .W     (W),
            .SHIFT (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (lnk_valid[i]),
            .in_ready  (lnk_ready[i]),
            .x_in      (lnk_x[i]),
            .y_in      (lnk_y[i]),
            .z_in      (lnk_z[i]),
            .flags_in  (lnk_flags[i]),
            .out_valid (lnk_valid[i+1]),
            .out_ready (lnk_ready[i+1]),
            .x_out     (lnk_x[i+1]),
            .y_out     (lnk_y[i+1]),
            .z_out     (lnk_z[i+1]),
            .flags_out (lnk_flags[i+1])
        );
    end

    // Normalization, rounding and output register.
    atan_post #(
        .AFB (ANGLE_FRAC_BITS)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lnk_valid[ITERATIONS]),
        .in_ready  (lnk_ready[ITERATIONS]),
        .z_in      (lnk_z[ITERATIONS]),
        .flags_in  (lnk_flags[ITERATIONS]),
        .out_valid (angle.valid),
        .out_ready (angle.ready),
        .angle_out (angle.angle_deg_q7)
    );

    // An empty first cell always takes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !lnk_valid[0] |-> coord.ready)
    else $error("input refused while first cell is empty");
endmodule

>>> tb/atan2_angle_degrees_tb.sv
// Self-checking testbench for atan2_angle_degrees: directed corner pairs, then random pairs.
// Results are checked against a known probe angle or a bit-exact CORDIC predictor here.
// Depends on atan_pkg, atan_coord_if, atan_angle_if and the RTL under rtl.
module atan2_angle_degrees_tb
    import atan_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PAIRS = 2000;
    localparam int HOLD_AT      = 800;
    localparam int PAUSE_AT     = 1400;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = ITERATIONS_DEF + 3 + 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_PROBES   = 24;

    localparam logic [15:0] ANGLE_ZERO = 16'd0;
    localparam logic [15:0] ANGLE_HALF = 16'(180 << ANGLE_FRAC_BITS_DEF);

    // One directed pair; the angle is used only when known is set.
    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic               known;
        logic [15:0]        angle;
    } probe_t;

    // One outstanding result, with its input kept for reports.
    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic [15:0]        angle;
    } pending_t;

    localparam probe_t PROBES [0:NUM_PROBES-1] = '{
        '{16'sd0,      16'sd0,      1'b1, ANGLE_ZERO},
        '{16'sd0,      16'sd32767,  1'b1, ANGLE_ZERO},
        '{16'sd0,      16'sd1,      1'b1, ANGLE_ZERO},
        '{16'sd0,      -16'sd1,     1'b1, ANGLE_HALF},
        '{16'sd0,      16'sh8000,   1'b1, ANGLE_HALF},
        '{16'sd32767,  16'sd0,      1'b0, ANGLE_ZERO},
        '{16'sh8000,   16'sd0,      1'b0, ANGLE_ZERO},
        '{16'sd1,      16'sd0,      1'b0, ANGLE_ZERO},
        '{-16'sd1,     16'sd0,      1'b0, ANGLE_ZERO},
        '{16'sd32767,  16'sd32767,  1'b0, ANGLE_ZERO},
        '{16'sh8000,   16'sh8000,   1'b0, ANGLE_ZERO},
        '{16'sd32767,  16'sh8000,   1'b0, ANGLE_ZERO},
        '{16'sh8000,   16'sd32767,  1'b0, ANGLE_ZERO},
        '{16'sh8000,   16'sd32767,  1'b0, ANGLE_ZERO},
        '{-16'sd1,     16'sd32767,  1'b0, ANGLE_ZERO},
        '{16'sd1,      16'sd32767,  1'b0, ANGLE_ZERO},
        '{16'sd1,      16'sh8000,   1'b0, ANGLE_ZERO},
        '{-16'sd1,     16'sh8000,   1'b0, ANGLE_ZERO},
        '{16'sd1,      16'sd1,      1'b0, ANGLE_ZERO},
        '{-16'sd1,     -16'sd1,     1'b0, ANGLE_ZERO},
        '{16'sd1,      -16'sd1,     1'b0, ANGLE_ZERO},
        '{-16'sd1,     16'sd1,      1'b0, ANGLE_ZERO},
        '{16'sh8000,   -16'sd1,     1'b0, ANGLE_ZERO},
        '{16'sd32767,  -16'sd1,     1'b0, ANGLE_ZERO}
    };

    logic clk;
    logic rst_n;

    atan_coord_if #(.CW(16)) coord_ch();
    atan_angle_if            angle_ch();

    atan2_angle_degrees u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .coord (coord_ch),
        .angle (angle_ch)
    );

    pending_t    pending_angles[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    logic        offered_known  = 1'b0;
    logic [15:0] offered_angle  = '0;
    logic        hold_req       = 1'b0;

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Bit-exact vectoring CORDIC: degrees with 24 fraction bits, 16 guard bits on x and y.
    function automatic logic [15:0] cordic_angle_q7(logic signed [15:0] y_in,
                                                     logic signed [15:0] x_in);
        longint          y;
        longint          x;
        longint          z;
        longint          dx;
        longint          dy;
        longint unsigned rounded;
        y = y_in;
        x = x_in;
        z = 0;
        if (y == 0)
        begin
            return (x < 0) ? ANGLE_HALF : ANGLE_ZERO;
        end
        // Fold the left half plane onto the right one, starting from 180 degrees.
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = longint'(180) <<< ACC_FRAC;
        end
        x = x <<< GUARD_BITS;
        y = y <<< GUARD_BITS;
        for (int i = 0; i < ITERATIONS_DEF && i < TABLE_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ELEM_ANGLE[i]);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ELEM_ANGLE[i]);
            end
        end
        if (z < 0)
            z = z + (longint'(360) <<< ACC_FRAC);
        if (z < 0)
            z = 0;
        // Round half up to the output fraction bits; a full turn wraps to zero.
        rounded = (longint'(z) + (longint'(1) << (ACC_FRAC - ANGLE_FRAC_BITS_DEF - 1)))
                  >> (ACC_FRAC - ANGLE_FRAC_BITS_DEF);
        if (rounded >= (longint'(360) << ANGLE_FRAC_BITS_DEF))
            rounded = rounded - (longint'(360) << ANGLE_FRAC_BITS_DEF);
        return rounded[15:0];
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [15:0] near_zero(int span);
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // Random pair: full range, near the origin, near an axis or near a diagonal.
    task automatic pick_pair(output logic signed [15:0] y, output logic signed [15:0] x);
        logic signed [15:0] base;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                y = 16'($urandom);
                x = 16'($urandom);
            end
            2:
            begin
                y = near_zero(8);
                x = near_zero(8);
            end
            3:
            begin
                y = near_zero(2);
                x = 16'($urandom);
            end
            4:
            begin
                y = 16'($urandom);
                x = near_zero(2);
            end
            default:
            begin
                base = 16'($urandom);
                x = base;
                y = ($urandom_range(0, 1) != 0) ? base + near_zero(3) : -base + near_zero(3);
            end
        endcase
    endtask

    // Offer one pair, starting and ending at a falling edge.
    task automatic offer_pair(logic signed [15:0] y, logic signed [15:0] x,
                              logic known, logic [15:0] angle, int gap);
        if (gap > 0)
        begin
            coord_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        coord_ch.valid   <= 1'b1;
        coord_ch.y_coord <= y;
        coord_ch.x_coord <= x;
        offered_known = known;
        offered_angle = angle;
        @(posedge clk);
        while (!coord_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Result check first, then record the item taken at this edge.
    always @(posedge clk)
    begin
        pending_t head;
        pending_t entry;
        if (rst_n)
        begin
            if (angle_ch.valid && angle_ch.ready)
            begin
                if (pending_angles.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("unexpected result angle=%0d", angle_ch.angle_deg_q7);
                    mismatch_count++;
                end
                else
                begin
                    head = pending_angles.pop_front();
                    if (angle_ch.angle_deg_q7 !== head.angle)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                            $display("angle mismatch y=%0d x=%0d expected %0d got %0d",
                                     head.y, head.x, head.angle, angle_ch.angle_deg_q7);
                        mismatch_count++;
                    end
                end
            end
            if (coord_ch.valid && coord_ch.ready)
            begin
                entry.y = coord_ch.y_coord;
                entry.x = coord_ch.x_coord;
                entry.angle = offered_known ? offered_angle
                                            : cordic_angle_q7(coord_ch.y_coord, coord_ch.x_coord);
                pending_angles.push_back(entry);
            end
        end
    end

    // Result side: runs of ready, random stalls, and one long hold-off on request.
    initial
    begin
        int run;
        int n;
        int stall;
        angle_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                angle_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            angle_ch.ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
            n = 0;
            do
            begin
                @(negedge clk);
                n++;
            end
            while (n < run && !hold_req);
            stall = idle_len();
            if (stall > 0 && !hold_req)
            begin
                angle_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Coordinate side: reset, directed pairs, random pairs, then drain and verdict.
    initial
    begin
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic               steady;
        int                 gap;
        coord_ch.valid   = 1'b0;
        coord_ch.y_coord = '0;
        coord_ch.x_coord = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int k = 0; k < NUM_PROBES; k++)
            offer_pair(PROBES[k].y, PROBES[k].x, PROBES[k].known, PROBES[k].angle, idle_len());

        steady = 1'b0;
        for (int k = 0; k < RANDOM_PAIRS; k++)
        begin
            // Switch at random between gappy stretches and back-to-back stretches.
            if (k % 150 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (k == HOLD_AT)
                hold_req = 1'b1;
            // Stop offering until every outstanding result has come back.
            if (k == PAUSE_AT)
            begin
                coord_ch.valid <= 1'b0;
                @(negedge clk);
                while (pending_angles.size() != 0)
                    @(negedge clk);
            end
            gap = (steady || hold_req) ? 0 : idle_len();
            pick_pair(y, x);
            offer_pair(y, x, 1'b0, ANGLE_ZERO, gap);
        end
        coord_ch.valid <= 1'b0;

        while (pending_angles.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
